// ===== hdl/count_rescale_with_carry_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the count rescaler
// Concurrent checks on the clock and the active-low synchronous reset.
// ----------------------------------------------------------------------------
`ifndef COUNT_RESCALE_WITH_CARRY_ASSERT_SVH
`define COUNT_RESCALE_WITH_CARRY_ASSERT_SVH

// same-cycle implication
`define CRWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("count_rescale_with_carry: assertion failed");

// next-cycle implication
`define CRWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("count_rescale_with_carry: assertion failed");

`endif

// ===== hdl/crwc_pkg.sv =====
// ----------------------------------------------------------------------------
// Count rescaler package
// Widths, register indexes, state type and divider request/response types.
// ----------------------------------------------------------------------------
package crwc_pkg;

    localparam int CNT_W      = 16;
    localparam int REG_W      = 32;
    localparam int PROD_W     = CNT_W + REG_W;
    localparam int REM_W      = 34;
    localparam int Q_W        = PROD_W + 1;
    localparam int DIGIT_W    = 4;
    localparam int MUL_STEPS  = CNT_W / DIGIT_W;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int STEP_W     = $clog2(PROD_W + 1);
    localparam int ALIGN_W    = PROD_W - REM_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [STEP_W-1:0] DIV1_STEPS = STEP_W'(PROD_W);
    localparam logic [STEP_W-1:0] DIV2_STEPS = STEP_W'(REM_W);

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAGMENTS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FACTOR   = CFG_IDX_W'(1);

    localparam logic [REG_W-1:0] NF_RESET = REG_W'(1);
    localparam logic [REG_W-1:0] RF_RESET = REG_W'(10000000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV1,
        S_CHK,
        S_DIV2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [REG_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
        logic [REG_W-1:0]  remainder;
    } t_div_rsp;

endpackage

// ===== hdl/crwc_in_if.sv =====
// ----------------------------------------------------------------------------
// Count rescaler request channel
// Valid/ready channel carrying one count per request.
// ----------------------------------------------------------------------------
interface crwc_in_if import crwc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count_in;

    modport source (output valid, output count_in, input ready);
    modport sink   (input valid, input count_in, output ready);

endinterface

// ===== hdl/crwc_out_if.sv =====
// ----------------------------------------------------------------------------
// Count rescaler result channel
// Valid/ready channel carrying one rescaled count and its overflow flag.
// ----------------------------------------------------------------------------
interface crwc_out_if import crwc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count_out;
    logic             overflow;

    modport source (output valid, output count_out, output overflow, input ready);
    modport sink   (input valid, input count_out, input overflow, output ready);

endinterface

// ===== hdl/crwc_div.sv =====
// ----------------------------------------------------------------------------
// Radix-2 serial divider
// Restoring division, one quotient bit per cycle, over a left-aligned
// dividend for a requested number of steps.
// ----------------------------------------------------------------------------
module crwc_div import crwc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [PROD_W-1:0] r_dvd;
    logic [PROD_W-1:0] r_quo;
    logic [REG_W-1:0]  r_rmd;
    logic [REG_W-1:0]  r_dvs;

    logic [REG_W:0]    w_shift;
    logic [REG_W:0]    w_diff;
    logic              w_ge;

    assign w_shift = {r_rmd, r_dvd[PROD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_quo <= '0;
            r_rmd <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
            r_rmd <= w_ge ? w_diff[REG_W-1:0] : w_shift[REG_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rmd;

endmodule

// ===== hdl/count_rescale_with_carry.sv =====
// ----------------------------------------------------------------------------
// Count rescaler with carried remainder
// Scales each count by target_factor / total_fragments and pays out the
// collected division remainders once they reach target_factor.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one 16-bit count per request; o_rsp returns one rescaled
//   count with an overflow flag per request, in order.
//   Configuration: i_cfg_we with i_cfg_idx 0 writes total_fragments, index 1
//   writes target_factor; write only while no request is in flight.
//   A zero count skips the multiplier and the divider; the remainder payout
//   runs only when the carried remainder reaches target_factor.
//   One request at a time: the next is taken only once the previous result
//   is loaded into the output register. The 4-bit-per-cycle multiplier feeds
//   the shared radix-2 divider, which yields the quotient and, when needed,
//   the remainder payout.
//   Reset clears the carried remainder, sets total_fragments to 1 and
//   target_factor to 10000000, and drops any pending result.
//   A stalled receiver holds the result in the output register; the block
//   still takes and works one further request, then waits with it finished.
// ----------------------------------------------------------------------------
module count_rescale_with_carry import crwc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    crwc_in_if.sink              i_req,
    crwc_out_if.source           o_rsp
);

    t_state               r_state;
    t_state               n_state;

    logic [REG_W-1:0]     r_nf;
    logic [REG_W-1:0]     r_rf;
    logic [REM_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_c;
    logic [MUL_CNT_W-1:0] r_mcnt;
    logic [PROD_W-1:0]    r_p;
    logic [Q_W-1:0]       r_q;
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_out_cnt;
    logic                 r_out_ovf;

    logic                        w_accept;
    logic                        w_load_out;
    logic                        w_rem_hit;
    logic [REG_W-1:0]            w_nf;
    logic [DIGIT_W+REG_W-1:0]    w_prod;
    logic [REM_W-1:0]            w_rem_sum;
    t_div_req                    w_div_req;
    t_div_rsp                    w_div_rsp;

    crwc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign w_nf        = (r_nf == '0) ? REG_W'(1) : r_nf;
    assign w_prod      = (DIGIT_W+REG_W)'(r_c[CNT_W-1 -: DIGIT_W])
                         * (DIGIT_W+REG_W)'(r_rf);
    assign w_rem_sum   = r_rem + REM_W'(w_div_rsp.remainder);
    assign w_rem_hit   = (r_rf != '0) && (r_rem >= REM_W'(r_rf));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state            = r_state;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_p;
        w_div_req.divisor  = w_nf;
        w_div_req.steps    = DIV1_STEPS;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.count_in == '0) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                if (r_mcnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                w_div_req.start = 1'b1;
                n_state         = S_DIV1;
            end
            S_DIV1: begin
                if (w_div_rsp.done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                w_div_req.dividend = {r_rem, {ALIGN_W{1'b0}}};
                w_div_req.divisor  = r_rf;
                w_div_req.steps    = DIV2_STEPS;
                if (w_rem_hit) begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV2: begin
                if (w_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf  <= NF_RESET;
            r_rf  <= RF_RESET;
            r_rem <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOTAL_FRAGMENTS: r_nf <= i_cfg_data;
                    CFG_TARGET_FACTOR:   r_rf <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DIV1 && w_div_rsp.done) begin
                r_rem <= w_rem_sum;
            end else if (r_state == S_DIV2 && w_div_rsp.done) begin
                r_rem <= REM_W'(w_div_rsp.remainder);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_c    <= i_req.count_in;
                r_mcnt <= '0;
                r_p    <= '0;
                r_q    <= '0;
            end
            S_MUL: begin
                r_p    <= {r_p[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(w_prod);
                r_c    <= {r_c[CNT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                r_mcnt <= r_mcnt + MUL_CNT_W'(1);
            end
            S_DIV1: begin
                if (w_div_rsp.done) begin
                    r_q <= Q_W'(w_div_rsp.quotient);
                end
            end
            S_DIV2: begin
                if (w_div_rsp.done) begin
                    r_q <= r_q + Q_W'(w_div_rsp.quotient);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_cnt <= r_q[CNT_W-1:0];
            r_out_ovf <= |r_q[Q_W-1:CNT_W];
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.count_out = r_out_cnt;
    assign o_rsp.overflow  = r_out_ovf;

endmodule

// ===== hdl/crwc_chk.sv =====
// ----------------------------------------------------------------------------
// Count rescaler port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`include "count_rescale_with_carry_assert.svh"

module crwc_chk import crwc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic [CNT_W-1:0] i_count_in,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [CNT_W-1:0] i_count_out,
    input logic             i_overflow
);

    `CRWC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `CRWC_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_count_out) && $stable(i_overflow))
    `CRWC_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `CRWC_ASSERT_IMP(a_zero_pass, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_count_in == '0) && !i_out_valid, ##2 (i_out_valid && (i_count_out == '0) && !i_overflow))

endmodule

bind count_rescale_with_carry crwc_chk u_crwc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_count_in  (i_req.count_in),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_count_out (o_rsp.count_out),
    .i_overflow  (o_rsp.overflow)
);
